FILE: hdl/message_slot_mailbox_core_macros.svh
// Assertion macros for the message slot mailbox.
// Used by message_slot_mailbox_core; no other dependencies.
`ifndef MESSAGE_SLOT_MAILBOX_CORE_MACROS_SVH
`define MESSAGE_SLOT_MAILBOX_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mailbox assertion failed");
`define MSM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mailbox reset assertion failed");
`else
`define MSM_ASSERT(label, prop)
`define MSM_ASSERT_RST(label, prop)
`endif
`endif

FILE: hdl/msm_pkg.sv
// Shared types and constants of the message slot mailbox.
// No dependencies; used by msm_front, msm_queue, msm_back, the core and the testbench.
`default_nettype none
package msm_pkg;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_FIND_MSG = 2'd1,
    OP_FIND_RCV = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    RS_STORED     = 4'd0,
    RS_OVERWROTE  = 4'd1,
    RS_DROPPED    = 4'd2,
    RS_FULL       = 4'd3,
    RS_MATCH      = 4'd4,
    RS_COUNT      = 4'd5,
    RS_READ_OK    = 4'd6,
    RS_NOT_IN_USE = 4'd7,
    RS_TOO_LONG   = 4'd8,
    RS_ABORTED    = 4'd9
  } status_e;

  // Stored slot contents
  typedef struct packed {
    logic [31:0] msg_id;
    logic [31:0] src_id;
    logic [31:0] dst_id;
    logic [31:0] int_payload;
    logic [31:0] float_bits;
  } entry_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    entry_t      data;
    logic        must_deliver;
    logic [5:0]  entry_index;
    logic        entry_in_range;
    logic        batch_last;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot_index;
    logic [6:0]  match_count;
    entry_t      data;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int unsigned QueueDepth = 2;

  function automatic result_t make_res(status_e st, logic [5:0] idx, logic [6:0] cnt,
                                       logic last);
    result_t r;
    r.status      = st;
    r.slot_index  = idx;
    r.match_count = cnt;
    r.data        = '0;
    r.last_result = last;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/msm_if.sv
// Valid/ready channel interfaces for mailbox commands and results.
// No dependencies.
`default_nettype none
interface msm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] msg_id;
  logic signed [31:0] src_id;
  logic signed [31:0] dst_id;
  logic signed [31:0] int_payload;
  logic [31:0]        float_bits;
  logic               must_deliver;
  logic [5:0]         entry_index;
  logic               batch_last;

  modport source (output valid, op, msg_id, src_id, dst_id, int_payload,
                  float_bits, must_deliver, entry_index, batch_last, input ready);
  modport sink (input valid, op, msg_id, src_id, dst_id, int_payload,
                float_bits, must_deliver, entry_index, batch_last, output ready);
endinterface

interface msm_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic [5:0]         slot_index;
  logic [6:0]         match_count;
  logic signed [31:0] got_msg_id;
  logic signed [31:0] got_src_id;
  logic signed [31:0] got_dst_id;
  logic signed [31:0] got_int_payload;
  logic [31:0]        got_float_bits;
  logic               last_result;

  modport source (output valid, status, slot_index, match_count, got_msg_id,
                  got_src_id, got_dst_id, got_int_payload, got_float_bits,
                  last_result, input ready);
  modport sink (input valid, status, slot_index, match_count, got_msg_id,
                got_src_id, got_dst_id, got_int_payload, got_float_bits,
                last_result, output ready);
endinterface
`default_nettype wire

FILE: hdl/msm_front.sv
// Front end: accepts input words and classifies them into commands.
// Depends on msm_pkg and msm_in_if.
`default_nettype none
module msm_front
  import msm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  msm_in_if.sink   in_if,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW   = (IdxW > 6) ? IdxW + 1 : 7;

  assign in_if.ready = !q_stat_i.full;
  assign push_o      = in_if.valid && in_if.ready;

  // Pick the search key and flag indexes beyond the table
  always_comb begin
    cmd_o.op                = op_e'(in_if.op);
    cmd_o.key               = (in_if.op == OP_FIND_MSG) ? in_if.msg_id : in_if.dst_id;
    cmd_o.data.msg_id       = in_if.msg_id;
    cmd_o.data.src_id       = in_if.src_id;
    cmd_o.data.dst_id       = in_if.dst_id;
    cmd_o.data.int_payload  = in_if.int_payload;
    cmd_o.data.float_bits   = in_if.float_bits;
    cmd_o.must_deliver      = in_if.must_deliver;
    cmd_o.entry_index       = in_if.entry_index;
    cmd_o.entry_in_range    = EW'(in_if.entry_index) < EW'(TABLE_DEPTH);
    cmd_o.batch_last        = in_if.batch_last;
  end

endmodule
`default_nettype wire

FILE: hdl/msm_queue.sv
// Two-entry command queue between front and back ends.
// Depends on msm_pkg.
`default_nettype none
module msm_queue
  import msm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;

  assign stat_o.full  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/msm_back.sv
// Back end: slot table, scan sequencer, batch state and result register.
// Depends on msm_pkg and msm_out_if.
`default_nettype none
module msm_back
  import msm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned LIST_LIMIT  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_avail_i,
  output logic      pop_o,
  msm_out_if.source out_if
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW   = (IdxW > 6) ? IdxW + 1 : 7;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD_OUT, S_SC_RD, S_SC_CMP, S_CNT
  } state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [IdxW-1:0]        scan_q;
  logic [6:0]             listed_q, count_q;
  logic [TABLE_DEPTH-1:0] valid_q, prot_q;
  logic [63:0]            pend_q;
  logic [6:0]             blen_q;
  logic                   abort_q;
  result_t                res_q;
  logic                   res_valid_q;

  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rdata_q;
  logic [IdxW-1:0]        rd_addr, entry_addr, wr_addr;
  logic                   wr_en;

  logic                   can_emit;
  logic                   free_found, unprot_found;
  logic [IdxW-1:0]        free_idx, unprot_idx;
  logic                   hit, list_it;
  logic [6:0]             listed_n, count_n;
  logic                   scan_done;
  logic [63:0]            pend_n;
  logic                   rd_good, emit;

  assign can_emit   = !res_valid_q || out_if.ready;
  assign pop_o      = (state_q == S_IDLE) && cmd_avail_i;
  assign entry_addr = IdxW'(EW'(cmd_q.entry_index));
  assign rd_addr    = (cmd_q.op == OP_READ) ? entry_addr : scan_q;
  assign wr_addr    = free_found ? free_idx : unprot_idx;
  assign wr_en      = (state_q == S_EXEC) && (cmd_q.op == OP_INSERT) && can_emit &&
                      (free_found || unprot_found);
  assign pend_n     = pend_q | (64'd1 << cmd_q.entry_index);
  assign rd_good    = !abort_q && (blen_q < 7'(LIST_LIMIT)) && cmd_q.entry_in_range &&
                      valid_q[entry_addr];

  // Lowest free slot and lowest unprotected used slot
  always_comb begin
    free_found   = 1'b0;
    unprot_found = 1'b0;
    free_idx     = '0;
    unprot_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
      if (valid_q[i] && !prot_q[i]) begin
        unprot_found = 1'b1;
        unprot_idx   = IdxW'(i);
      end
    end
  end

  // Scan compare for the finds
  always_comb begin
    hit       = valid_q[scan_q] &&
                (cmd_q.key == ((cmd_q.op == OP_FIND_MSG) ? rdata_q.msg_id
                                                         : rdata_q.dst_id));
    list_it   = hit && (listed_q < 7'(LIST_LIMIT));
    listed_n  = list_it ? listed_q + 7'd1 : listed_q;
    count_n   = (hit && count_q != 7'd127) ? count_q + 7'd1 : count_q;
    scan_done = (scan_q == IdxW'(TABLE_DEPTH - 1)) ||
                ((cmd_q.op == OP_FIND_MSG) && (listed_n >= 7'(LIST_LIMIT)));
  end

  // A result word is loaded in this cycle
  always_comb begin
    unique case (state_q)
      S_EXEC:          emit = can_emit && ((cmd_q.op == OP_INSERT) ||
                                           ((cmd_q.op == OP_READ) && !rd_good));
      S_RD_OUT, S_CNT: emit = can_emit;
      S_SC_CMP:        emit = can_emit && list_it;
      default:         emit = 1'b0;
    endcase
  end

  // Slot store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_q.data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Sequencer, slot flags, batch state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      scan_q      <= '0;
      listed_q    <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      prot_q      <= '0;
      pend_q      <= '0;
      blen_q      <= '0;
      abort_q     <= 1'b0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (emit) res_valid_q <= 1'b1;
      else if (out_if.ready) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_avail_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q.op) inside
            OP_INSERT: begin
              if (can_emit) begin
                state_q <= S_IDLE;
                if (free_found || unprot_found) begin
                  valid_q[wr_addr] <= 1'b1;
                  prot_q[wr_addr]  <= cmd_q.must_deliver;
                  res_q <= make_res(free_found ? RS_STORED : RS_OVERWROTE,
                                    6'(wr_addr), 7'd0, 1'b1);
                end else begin
                  res_q <= make_res(cmd_q.must_deliver ? RS_FULL : RS_DROPPED,
                                    6'd0, 7'd0, 1'b1);
                end
              end
            end
            OP_FIND_MSG, OP_FIND_RCV: begin
              scan_q   <= '0;
              listed_q <= '0;
              count_q  <= '0;
              state_q  <= S_SC_RD;
            end
            default: begin
              // read and free: errors answer here, good reads wait for data
              if (rd_good) begin
                state_q <= S_RD_OUT;
              end else if (can_emit) begin
                state_q     <= S_IDLE;
                if (abort_q)
                  res_q <= make_res(RS_ABORTED, cmd_q.entry_index, 7'd0, 1'b1);
                else if (blen_q >= 7'(LIST_LIMIT))
                  res_q <= make_res(RS_TOO_LONG, cmd_q.entry_index, 7'd0, 1'b1);
                else
                  res_q <= make_res(RS_NOT_IN_USE, cmd_q.entry_index, 7'd0, 1'b1);
                if (cmd_q.batch_last) begin
                  pend_q  <= '0;
                  blen_q  <= '0;
                  abort_q <= 1'b0;
                end else begin
                  abort_q <= 1'b1;
                end
              end
            end
          endcase
        end
        S_RD_OUT: begin
          if (can_emit) begin
            res_q   <= {RS_READ_OK, cmd_q.entry_index, 7'd0, rdata_q, 1'b1};
            state_q <= S_IDLE;
            if (cmd_q.batch_last) begin
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (i < 64 && pend_n[6'(i)]) valid_q[i] <= 1'b0;
              end
              pend_q <= '0;
              blen_q <= '0;
            end else begin
              pend_q <= pend_n;
              blen_q <= blen_q + 7'd1;
            end
          end
        end
        S_SC_RD: begin
          state_q <= S_SC_CMP;
        end
        S_SC_CMP: begin
          if (!list_it || can_emit) begin
            if (list_it) begin
              res_q          <= make_res(RS_MATCH, 6'(scan_q), 7'd0, 1'b0);
              prot_q[scan_q] <= 1'b1;
            end
            listed_q <= listed_n;
            count_q  <= count_n;
            if (scan_done) begin
              state_q <= S_CNT;
            end else begin
              scan_q  <= scan_q + 1'b1;
              state_q <= S_SC_RD;
            end
          end
        end
        S_CNT: begin
          if (can_emit) begin
            res_q       <= make_res(RS_COUNT, 6'd0, count_q, 1'b1);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid           = res_valid_q;
  assign out_if.status          = res_q.status;
  assign out_if.slot_index      = res_q.slot_index;
  assign out_if.match_count     = res_q.match_count;
  assign out_if.got_msg_id      = res_q.data.msg_id;
  assign out_if.got_src_id      = res_q.data.src_id;
  assign out_if.got_dst_id      = res_q.data.dst_id;
  assign out_if.got_int_payload = res_q.data.int_payload;
  assign out_if.got_float_bits  = res_q.data.float_bits;
  assign out_if.last_result     = res_q.last_result;

endmodule
`default_nettype wire

FILE: hdl/message_slot_mailbox_core.sv
// Message slot mailbox: a table of message slots with insert, find and
// read-and-free. Channels: in_if (command words) and out_if (result words),
// both valid/ready; a word moves when valid and ready are high at a clock edge.
// Insert and a read give one result word; a find gives one match word per
// listed slot (at most LIST_LIMIT) and then a count word, last_result marking
// the end. An insert is worked in the execute state, a good read in the
// execute and then the read-out state, and a find alternates a read and a
// compare state for each slot scanned (TABLE_DEPTH slots, fewer when the
// message-id list fills) before the count state. The scan speed is set by
// the single read port of the slot store. One command is worked at a time.
// A two-word command queue lets the input keep accepting while the back end
// works or the receiver stalls; a stalled receiver holds the result register
// and the back end waits on it, and once the queue is full the input stalls.
// Reset clears the valid and protect flags and the batch state; slot contents
// need no clearing pass.
// Depends on msm_pkg, msm_if, msm_front, msm_queue, msm_back and the macros.
`default_nettype none
`include "message_slot_mailbox_core_macros.svh"
module message_slot_mailbox_core
  import msm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned LIST_LIMIT  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msm_in_if.sink    in_if,
  msm_out_if.source out_if
);

  logic    push, pop;
  cmd_t    front_cmd, q_cmd;
  q_stat_t q_stat;

  msm_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .in_if    (in_if),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  msm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  msm_back #(.TABLE_DEPTH(TABLE_DEPTH), .LIST_LIMIT(LIST_LIMIT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_avail_i (!q_stat.empty),
    .pop_o       (pop),
    .out_if      (out_if)
  );

  // Checks
  `MSM_ASSERT(a_no_overflow, push |-> !q_stat.full || pop)
  `MSM_ASSERT(a_no_underflow, pop |-> !q_stat.empty)
  `MSM_ASSERT(a_match_not_last, out_if.valid && out_if.status == RS_MATCH |-> !out_if.last_result)
  `MSM_ASSERT(a_count_only, out_if.valid && out_if.match_count != 7'd0 |-> out_if.status == RS_COUNT)
  `MSM_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_if.valid)

endmodule
`default_nettype wire

FILE: verif/tb_message_slot_mailbox_core.sv
// Self-checking testbench for message_slot_mailbox_core: drives command words,
// predicts result words with a scoreboard class and compares them in order.
// Depends on msm_pkg, msm_if and the RTL of the block.
`timescale 1ns / 1ps
module tb_message_slot_mailbox_core;
  import msm_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned ListMax = 32;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    op_e         op;
    logic [31:0] msg_id;
    logic [31:0] src_id;
    logic [31:0] dst_id;
    logic [31:0] int_payload;
    logic [31:0] float_bits;
    logic        must_deliver;
    logic [5:0]  entry_index;
    logic        batch_last;
  } cmd_word_t;

  // Predictor of the mailbox plus queue of expected result words
  class mailbox_scoreboard;
    bit          used[Depth];
    bit          locked[Depth];
    entry_t      store[Depth];
    logic [63:0] free_mask = '0;
    int unsigned batch_len;
    bit          batch_dead;
    result_t     expected_q[$];
    int unsigned errors;

    function void add_expected(status_e st, int unsigned idx, int unsigned cnt, int slot,
                               bit last);
      result_t r;
      r = make_res(st, idx[5:0], cnt[6:0], last);
      if (slot >= 0) r.data = store[slot];
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void place(int i, cmd_word_t c);
      store[i] = {c.msg_id, c.src_id, c.dst_id, c.int_payload, c.float_bits};
      used[i] = 1;
      locked[i] = c.must_deliver;
    endfunction

    function void note_command(cmd_word_t c);
      int unsigned listed;
      int unsigned hits;
      int idx;
      logic [31:0] key;
      listed = 0;
      hits = 0;
      idx = -1;
      case (c.op) inside
        OP_INSERT: begin
          foreach (used[i]) if (idx < 0 && !used[i]) idx = i;
          if (idx >= 0) begin
            place(idx, c);
            add_expected(RS_STORED, idx, 0, -1, 1);
          end else begin
            foreach (used[i]) if (idx < 0 && !locked[i]) idx = i;
            if (idx >= 0) begin
              place(idx, c);
              add_expected(RS_OVERWROTE, idx, 0, -1, 1);
            end else if (c.must_deliver) begin
              add_expected(RS_FULL, 0, 0, -1, 1);
            end else begin
              add_expected(RS_DROPPED, 0, 0, -1, 1);
            end
          end
        end
        OP_FIND_MSG, OP_FIND_RCV: begin
          key = (c.op == OP_FIND_MSG) ? c.msg_id : c.dst_id;
          for (int i = 0; i < Depth; i++) begin
            if (c.op == OP_FIND_MSG && listed >= ListMax) break;
            if (used[i] && ((c.op == OP_FIND_MSG) ? store[i].msg_id
                                                  : store[i].dst_id) == key) begin
              if (listed < ListMax) begin
                add_expected(RS_MATCH, i, 0, -1, 0);
                locked[i] = 1;
                listed++;
              end
              if (hits < 127) hits++;
            end
          end
          add_expected(RS_COUNT, 0, hits, -1, 1);
        end
        default: begin
          if (batch_dead) begin
            add_expected(RS_ABORTED, c.entry_index, 0, -1, 1);
          end else if (batch_len >= ListMax) begin
            batch_dead = 1;
            add_expected(RS_TOO_LONG, c.entry_index, 0, -1, 1);
          end else if (!used[c.entry_index]) begin
            batch_dead = 1;
            add_expected(RS_NOT_IN_USE, c.entry_index, 0, -1, 1);
          end else begin
            add_expected(RS_READ_OK, c.entry_index, 0, c.entry_index, 1);
            free_mask[c.entry_index] = 1'b1;
            batch_len++;
          end
          if (c.batch_last) begin
            if (!batch_dead) foreach (used[i]) if (free_mask[i]) used[i] = 0;
            free_mask = '0;
            batch_len = 0;
            batch_dead = 0;
          end
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: expected st=%0d idx=%0d cnt=%0d data=%h last=%0d,",
                    " got st=%0d idx=%0d cnt=%0d data=%h last=%0d"},
                   want.status, want.slot_index, want.match_count, want.data,
                   want.last_result, got.status, got.slot_index, got.match_count,
                   got.data, got.last_result);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  msm_in_if  cmd_if ();
  msm_out_if res_if ();

  message_slot_mailbox_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (cmd_if),
    .out_if(res_if)
  );

  mailbox_scoreboard sb;
  longint unsigned cycles;
  bit stim_done;
  logic [31:0] id_pool[4];
  logic [5:0] read_pick;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.op = OP_INSERT;
    cmd_if.msg_id = '0;
    cmd_if.src_id = '0;
    cmd_if.dst_id = '0;
    cmd_if.int_payload = '0;
    cmd_if.float_bits = '0;
    cmd_if.must_deliver = 1'b0;
    cmd_if.entry_index = '0;
    cmd_if.batch_last = 1'b0;
  end

  // Send one command word and note it once it is taken
  task automatic send(cmd_word_t c);
    int unsigned idle;
    idle = $urandom_range(0, 3);
    if (idle > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op <= c.op;
    cmd_if.msg_id <= c.msg_id;
    cmd_if.src_id <= c.src_id;
    cmd_if.dst_id <= c.dst_id;
    cmd_if.int_payload <= c.int_payload;
    cmd_if.float_bits <= c.float_bits;
    cmd_if.must_deliver <= c.must_deliver;
    cmd_if.entry_index <= c.entry_index;
    cmd_if.batch_last <= c.batch_last;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(c);
  endtask

  function automatic cmd_word_t rand_word(op_e op);
    cmd_word_t c;
    c.op = op;
    c.msg_id = ($urandom_range(0, 3) == 0) ? $urandom() : id_pool[$urandom_range(0, 3)];
    c.src_id = $urandom();
    c.dst_id = ($urandom_range(0, 3) == 0) ? $urandom() : id_pool[$urandom_range(0, 3)];
    c.int_payload = $urandom();
    c.float_bits = $urandom();
    c.must_deliver = ($urandom_range(0, 3) == 0);
    c.entry_index = 6'($urandom_range(0, 63));
    c.batch_last = 1'b1;
    return c;
  endfunction

  // Result side: a drawn wait before each word, checks on every accepted word
  initial begin
    int unsigned hold;
    res_if.ready = 1'b0;
    forever begin
      hold = stim_done ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && res_if.valid && res_if.ready));
      sb.check_result({res_if.status, res_if.slot_index, res_if.match_count,
                       res_if.got_msg_id, res_if.got_src_id,
                       res_if.got_dst_id, res_if.got_int_payload,
                       res_if.got_float_bits, res_if.last_result});
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Pick a slot that is in use where possible
  function automatic logic [5:0] live_slot();
    for (int t = 0; t < 8; t++) begin
      read_pick = 6'($urandom_range(0, 63));
      if (sb.used[read_pick]) return read_pick;
    end
    return read_pick;
  endfunction

  initial begin
    cmd_word_t c;
    int unsigned blen;
    sb = new();
    stim_done = 0;
    foreach (id_pool[i]) id_pool[i] = $urandom();
    id_pool[0] = 32'h8000_0000;
    id_pool[1] = 32'h7fff_ffff;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, a find on the empty table, a read of an unused slot
    c = rand_word(OP_FIND_MSG);
    send(c);
    c = rand_word(OP_INSERT);
    c.msg_id = 32'h8000_0000; c.src_id = '1; c.dst_id = 32'h7fff_ffff;
    c.int_payload = 32'h8000_0000; c.float_bits = '1; c.must_deliver = 1;
    send(c);
    c = rand_word(OP_INSERT);
    c.msg_id = 32'h7fff_ffff; c.src_id = '0; c.dst_id = 32'h8000_0000;
    c.int_payload = 32'h7fff_ffff; c.float_bits = '0; c.must_deliver = 0;
    send(c);
    c = rand_word(OP_READ); c.entry_index = 6'd63; c.batch_last = 0; send(c);
    c.entry_index = 6'd0; send(c);
    c.batch_last = 1; send(c);
    c = rand_word(OP_READ); c.entry_index = 6'd0; c.batch_last = 1; send(c);
    // Fill the table with one shared receiver, protected then not
    for (int i = 0; i < 70; i++) begin
      c = rand_word(OP_INSERT);
      c.dst_id = id_pool[1]; c.msg_id = id_pool[0];
      c.must_deliver = (i < 40);
      send(c);
    end
    // Finds over a full table: message-id list fills, receiver count runs on
    c = rand_word(OP_FIND_MSG); c.msg_id = id_pool[0]; send(c);
    c = rand_word(OP_FIND_RCV); c.dst_id = id_pool[1]; send(c);
    // Inserts into a full table, protected and not
    c = rand_word(OP_INSERT); c.must_deliver = 1; send(c);
    c.must_deliver = 0; send(c);
    // Over-long batch, then a batch of full length that frees
    for (int i = 0; i < 34; i++) begin
      c = rand_word(OP_READ); c.entry_index = 6'(i); c.batch_last = (i == 33); send(c);
    end
    for (int i = 0; i < 32; i++) begin
      c = rand_word(OP_READ); c.entry_index = 6'(i); c.batch_last = (i == 31); send(c);
    end

    // Random part: mostly well-formed batches, with inserts and finds
    for (int n = 0; n < 75; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(rand_word(OP_INSERT));
        4: send(rand_word(OP_FIND_MSG));
        5: send(rand_word(OP_FIND_RCV));
        default: begin
          blen = $urandom_range(1, 4);
          for (int k = 0; k < blen; k++) begin
            c = rand_word(OP_READ);
            c.entry_index = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                        : live_slot();
            c.batch_last = (k == blen - 1);
            if (k > 0 && $urandom_range(0, 4) == 0) send(rand_word(OP_INSERT));
            send(c);
          end
          n += blen - 1;
        end
      endcase
    end

    cmd_if.valid <= 1'b0;
    stim_done = 1;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
